// ===== rtl/mf2d_pkg.sv =====
// shared types and constants for the 2d max filter
`timescale 1ns / 1ps
package mf2d_pkg;
  localparam int HALF_DIV = 2;
  localparam int MAX_ROWS = 4096;
  localparam int ROW_W    = 12;
  localparam int WIN_W    = 3;
  localparam int ROWS_W   = 13;
  localparam int COLS_W   = 7;
  localparam int CFG_W    = 13;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] CFG_WIN  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [IDX_W-1:0] CFG_COLS = 2'd2;

  typedef struct packed {
    logic emit;
    logic use_max;
    logic last;
    logic wr;
  } job_ctl_t;

  typedef struct packed {
    logic idle;
  } back_stat_t;
endpackage

// ===== rtl/mf2d_front.sv =====
// front end: position tracking, window classification and job building
`timescale 1ns / 1ps
module mf2d_front #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_WIN    = 7,
  parameter int PIXEL_BITS = 16,
  parameter int SW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1,
  parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  parameter int NW = $clog2(MAX_WIN + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mf2d_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [mf2d_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         acc_i,
  input  logic                         kind_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_value_i,
  output logic                         job_vld_o,
  output mf2d_pkg::job_ctl_t           job_ctl_o,
  output logic [PIXEL_BITS-1:0]        job_pix_o,
  output logic [SW-1:0]                job_wr_slot_o,
  output logic [CW-1:0]                job_wr_col_o,
  output logic [SW-1:0]                job_slot0_o,
  output logic [NW-1:0]                job_nrows_o,
  output logic [CW-1:0]                job_c0_o,
  output logic [NW-1:0]                job_ncols_o
);
  import mf2d_pkg::*;

  logic [WIN_W-1:0]  win_q;
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0]     in_col_q, in_col_d, out_col_q, out_col_d;
  logic [SW-1:0]     in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic              in_done_q, in_done_d;

  logic [1:0]        h;
  logic [ROWS_W-1:0] rows_e;
  logic [CW:0]       cols_e;
  logic              ok, is_pix, ready, last_o, last_i, done_mid;
  logic [ROW_W-1:0]  rmax, tr, r0;
  logic [CW-1:0]     cmax, tc, c0;
  logic [ROW_W:0]    tr_w;
  logic [CW+2:0]     tc_w;
  logic [1:0]        dr;
  logic [ROW_W-1:0]  nr_w;
  logic [CW-1:0]     nc_w;
  logic              cfg_hit;

  assign h      = 2'(win_q / HALF_DIV);
  assign is_pix = !kind_i;
  assign rows_e = (rows_q == '0) ? ROWS_W'(1) :
                  (rows_q > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_q;
  assign cols_e = (cols_q == '0) ? (CW+1)'(1) :
                  (32'(cols_q) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_q);
  assign ok = win_q[0] && (32'(win_q) <= MAX_WIN) && (ROWS_W'(win_q) <= rows_e)
              && (32'(win_q) <= 32'(cols_e));
  assign rmax = ROW_W'(rows_e - ROWS_W'(1));
  assign cmax = CW'(cols_e - (CW+1)'(1));
  assign tr_w = (ROW_W+1)'(out_row_q) + (ROW_W+1)'(h);
  assign tc_w = (CW+3)'(out_col_q) + (CW+3)'(h);
  assign tr   = (tr_w > (ROW_W+1)'(rmax)) ? rmax : ROW_W'(tr_w);
  assign tc   = (tc_w > (CW+3)'(cmax)) ? cmax : CW'(tc_w);
  assign ready = in_done_q || (in_row_q > tr) || (in_row_q == tr && in_col_q > tc);
  assign r0   = (out_row_q >= ROW_W'(h)) ? out_row_q - ROW_W'(h) : '0;
  assign c0   = (CW'(out_col_q) >= CW'(h) && (CW+3)'(out_col_q) >= (CW+3)'(h)) ?
                out_col_q - CW'(h) : '0;
  assign dr   = 2'(out_row_q - r0);
  assign nr_w = tr - r0 + ROW_W'(1);
  assign nc_w = tc - c0 + CW'(1);
  assign last_o = (out_row_q == rmax) && (out_col_q == cmax);
  assign last_i = (in_row_q == rmax) && (in_col_q == cmax);
  assign done_mid = (ok && ready && last_o) ? 1'b0 : in_done_q;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_WIN || cfg_idx_i == CFG_ROWS ||
                                cfg_idx_i == CFG_COLS);

  always_comb begin
    job_ctl_o.emit    = ok ? ready : is_pix;
    job_ctl_o.use_max = ok;
    job_ctl_o.last    = ok ? last_o : last_i;
    job_ctl_o.wr      = ok && is_pix && !done_mid;
    job_vld_o         = acc_i && (job_ctl_o.emit || job_ctl_o.wr);
    job_pix_o         = pixel_value_i;
    job_wr_slot_o     = in_slot_q;
    job_wr_col_o      = in_col_q;
    job_slot0_o       = (out_slot_q >= SW'(dr)) ? out_slot_q - SW'(dr) :
                        SW'(32'(out_slot_q) + MAX_WIN - 32'(dr));
    job_nrows_o       = NW'(nr_w);
    job_c0_o          = c0;
    job_ncols_o       = NW'(nc_w);
  end

  always_comb begin
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    in_done_d  = done_mid;
    if (ok && ready) begin
      if (last_o) begin
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
      end else if (out_col_q == cmax) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + ROW_W'(1);
        out_slot_d = (32'(out_slot_q) == MAX_WIN - 1) ? '0 : out_slot_q + SW'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
    if (is_pix && (!ok || !done_mid)) begin
      if (in_col_q == cmax) begin
        in_col_d = '0;
        if (in_row_q == rmax) begin
          in_row_d  = '0;
          in_slot_d = '0;
          if (ok) in_done_d = 1'b1;
        end else begin
          in_row_d  = in_row_q + ROW_W'(1);
          in_slot_d = (32'(in_slot_q) == MAX_WIN - 1) ? '0 : in_slot_q + SW'(1);
        end
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= WIN_W'(3);
      rows_q     <= ROWS_W'(8);
      cols_q     <= COLS_W'(8);
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      in_done_q  <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        CFG_WIN:  win_q  <= cfg_data_i[WIN_W-1:0];
        CFG_ROWS: rows_q <= cfg_data_i[ROWS_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[COLS_W-1:0];
        default:  win_q  <= win_q;
      endcase
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      in_done_q  <= 1'b0;
    end else if (acc_i) begin
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      in_done_q  <= in_done_d;
    end
  end
endmodule

// ===== rtl/mf2d_queue.sv =====
// two-entry job queue between front and back
`timescale 1ns / 1ps
module mf2d_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic         vld_o,
  output logic [W-1:0] rdata_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign vld_o   = cnt_q != 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= !wp_q;
      if (rd_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end
endmodule

// ===== rtl/mf2d_back.sv =====
// back end: line store, window scan and result register
`timescale 1ns / 1ps
module mf2d_back #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_WIN    = 7,
  parameter int PIXEL_BITS = 16,
  parameter int SW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1,
  parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  parameter int NW = $clog2(MAX_WIN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_vld_i,
  output logic                          job_pop_o,
  input  mf2d_pkg::job_ctl_t            job_ctl_i,
  input  logic [PIXEL_BITS-1:0]         job_pix_i,
  input  logic [SW-1:0]                 job_wr_slot_i,
  input  logic [CW-1:0]                 job_wr_col_i,
  input  logic [SW-1:0]                 job_slot0_i,
  input  logic [NW-1:0]                 job_nrows_i,
  input  logic [CW-1:0]                 job_c0_i,
  input  logic [NW-1:0]                 job_ncols_i,
  output mf2d_pkg::back_stat_t          stat_o,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [PIXEL_BITS-1:0]  result_value_o,
  output logic                          result_ok_o,
  output logic                          result_last_o
);
  import mf2d_pkg::*;

  localparam int DEPTH = MAX_WIN * MAX_COLS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_WAIT = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [1:0]            st_q, st_d;
  job_ctl_t              ctl_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [SW-1:0]         wslot_q, slot_q;
  logic [CW-1:0]         wcol_q, col_q, c0_q;
  logic [NW-1:0]         rcnt_q, ccnt_q, ncols_q;
  logic signed [PIXEL_BITS-1:0] best_q, rd_data_q;
  logic                  rd_vld_q, rd_last_q, res_vld_q;
  logic                  issue_last, go;
  logic [AW-1:0]         raddr, waddr;

  assign raddr = AW'(slot_q) * AW'(MAX_COLS) + AW'(col_q);
  assign waddr = AW'(wslot_q) * AW'(MAX_COLS) + AW'(wcol_q);
  assign issue_last = (rcnt_q == NW'(1)) && (ccnt_q == NW'(1));
  assign go = !ctl_q.emit || !res_vld_q || pop;
  assign job_pop_o = (st_q == B_IDLE) && job_vld_i;
  assign stat_o.idle = st_q == B_IDLE;
  assign empty = !res_vld_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: if (job_vld_i) begin
        st_d = (job_ctl_i.use_max && job_ctl_i.emit) ? B_READ : B_EMIT;
      end
      B_READ: if (issue_last) st_d = B_WAIT;
      B_WAIT: if (rd_vld_q && rd_last_q) st_d = B_EMIT;
      B_EMIT: if (go) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[raddr];
    if (st_q == B_EMIT && go && ctl_q.wr) mem[waddr] <= pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ctl_q   <= job_ctl_i;
      pix_q   <= job_pix_i;
      wslot_q <= job_wr_slot_i;
      wcol_q  <= job_wr_col_i;
      slot_q  <= job_slot0_i;
      col_q   <= job_c0_i;
      c0_q    <= job_c0_i;
      rcnt_q  <= job_nrows_i;
      ccnt_q  <= job_ncols_i;
      ncols_q <= job_ncols_i;
      best_q  <= {1'b1, {(PIXEL_BITS-1){1'b0}}};
    end else begin
      if (st_q == B_READ) begin
        if (ccnt_q == NW'(1)) begin
          ccnt_q <= ncols_q;
          col_q  <= c0_q;
          rcnt_q <= rcnt_q - NW'(1);
          slot_q <= (32'(slot_q) == MAX_WIN - 1) ? '0 : slot_q + SW'(1);
        end else begin
          ccnt_q <= ccnt_q - NW'(1);
          col_q  <= col_q + CW'(1);
        end
      end
      if (rd_vld_q && rd_data_q > best_q) best_q <= rd_data_q;
    end
    if (st_q == B_EMIT && go && ctl_q.emit) begin
      result_value_o <= ctl_q.use_max ? best_q : pix_q;
      result_ok_o    <= ctl_q.use_max;
      result_last_o  <= ctl_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_IDLE;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      rd_vld_q  <= st_q == B_READ;
      rd_last_q <= (st_q == B_READ) && issue_last;
      if (st_q == B_EMIT && go && ctl_q.emit) res_vld_q <= 1'b1;
      else if (pop) res_vld_q <= 1'b0;
    end
  end
endmodule

// ===== rtl/max_filter_2d.sv =====
// top level of the 2d square-window max filter
`timescale 1ns / 1ps
// Pixels enter in raster order through push/full; results leave through empty/pop.
// A filtered result takes one line-store read per pixel of its clipped window, all
// through the single read port of the line store; pass-through results and pure
// store writes need no reads. A two-entry job queue lets the input side run ahead
// of the window scan. Line store contents are undefined after reset and need no
// clearing; a configuration write to the window, rows or columns register restarts
// the frame.
module max_filter_2d #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_WIN    = 7,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mf2d_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [mf2d_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [PIXEL_BITS-1:0] result_value_o,
  output logic                         result_ok_o,
  output logic                         result_last_o
);
  import mf2d_pkg::*;

  localparam int SW = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NW = $clog2(MAX_WIN + 1);
  localparam int JW = $bits(job_ctl_t) + PIXEL_BITS + 2 * SW + 2 * CW + 2 * NW;

  logic                  acc, f_vld, q_full, q_vld, q_pop;
  job_ctl_t              f_ctl, b_ctl;
  logic [PIXEL_BITS-1:0] f_pix, b_pix;
  logic [SW-1:0]         f_wslot, f_slot0, b_wslot, b_slot0;
  logic [CW-1:0]         f_wcol, f_c0, b_wcol, b_c0;
  logic [NW-1:0]         f_nr, f_nc, b_nr, b_nc;
  logic [JW-1:0]         q_in, q_out;
  back_stat_t            b_stat;

  assign full = q_full;
  assign acc  = push && !q_full;
  assign q_in = {f_ctl, f_pix, f_wslot, f_wcol, f_slot0, f_nr, f_c0, f_nc};
  assign {b_ctl, b_pix, b_wslot, b_wcol, b_slot0, b_nr, b_c0, b_nc} = q_out;

  mf2d_front #(.MAX_COLS(MAX_COLS), .MAX_WIN(MAX_WIN), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .acc_i(acc), .kind_i, .pixel_value_i,
    .job_vld_o(f_vld), .job_ctl_o(f_ctl), .job_pix_o(f_pix),
    .job_wr_slot_o(f_wslot), .job_wr_col_o(f_wcol), .job_slot0_o(f_slot0),
    .job_nrows_o(f_nr), .job_c0_o(f_c0), .job_ncols_o(f_nc)
  );

  mf2d_queue #(.W(JW)) u_queue (
    .clk_i, .rst_ni, .wr_i(f_vld), .wdata_i(q_in), .full_o(q_full),
    .rd_i(q_pop), .vld_o(q_vld), .rdata_o(q_out)
  );

  mf2d_back #(.MAX_COLS(MAX_COLS), .MAX_WIN(MAX_WIN), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk_i, .rst_ni, .job_vld_i(q_vld), .job_pop_o(q_pop), .job_ctl_i(b_ctl),
    .job_pix_i(b_pix), .job_wr_slot_i(b_wslot), .job_wr_col_i(b_wcol),
    .job_slot0_i(b_slot0), .job_nrows_i(b_nr), .job_c0_i(b_c0), .job_ncols_i(b_nc),
    .stat_o(b_stat), .empty, .pop, .result_value_o, .result_ok_o, .result_last_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(f_vld && q_full)) else $error("job queue overflow");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (b_stat.idle && q_vld)) else $error("job taken while back busy");
  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !b_stat.idle) else $error("back stayed idle after taking a job");
endmodule
